// ===== rtl/ipfx_pkg.sv =====
package ipfx_pkg;

    // Address geometry
    localparam int GROUPS   = 8;
    localparam int GROUP_W  = 16;
    localparam int ADDR_W   = GROUPS * GROUP_W;
    localparam int CNT_W    = $clog2(GROUPS + 1);
    localparam int IDX_W    = $clog2(GROUPS);
    localparam int HALF_W   = ADDR_W / 2;

    // Prefix length limits
    localparam int PFX_ACC_W   = 10;
    localparam int PFX_W       = 8;
    localparam int PFX_DIGITS  = 3;
    localparam int PFX_CNT_W   = 2;
    localparam logic [PFX_ACC_W-1:0] PREFIX_MAX = PFX_ACC_W'(128);

    // Indent counter
    localparam int TAB_W = 8;

    // Character codes
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;

    // One finished line, handed from the parser to the result stage
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PFX_W-1:0]  prefix_length;
        logic              prefix_invalid;
        logic              form_invalid;
        logic [TAB_W-1:0]  indent_depth;
    } line_result_t;

    // Hex digit decode: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= CHAR_LC_A && c <= CHAR_LC_F) || (c >= CHAR_UC_A && c <= CHAR_UC_F)) begin
            // 'a'..'f' and 'A'..'F' share low bits 1..6
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== rtl/ipfx_parser.sv =====
module ipfx_parser
    import ipfx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic [7:0]   item_char,
    input  logic         item_eol,
    output logic         item_ready,
    output logic         snap_valid,
    output line_result_t snap,
    input  logic         snap_ready
);

    // Parse state
    logic [GROUP_W-1:0]   head_reg [GROUPS];
    logic [GROUP_W-1:0]   head_next [GROUPS];
    logic [ADDR_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 gap_seen_reg, gap_seen_next;
    logic [GROUP_W-1:0]   hex_reg, hex_next;
    logic                 digit_reg, digit_next;
    logic                 prev_colon_reg, prev_colon_next;
    logic                 in_prefix_reg, in_prefix_next;
    logic [PFX_ACC_W-1:0] prefix_reg, prefix_next;
    logic [PFX_CNT_W-1:0] pdc_reg, pdc_next;
    logic [TAB_W-1:0]     tab_reg, tab_next;
    logic                 bad_reg, bad_next;
    logic                 snap_valid_reg, snap_valid_next;
    line_result_t         snap_reg, snap_next;

    logic                 fire;
    logic                 close_now;
    logic [GROUP_W-1:0]   hex_c;
    logic                 digit_c;
    logic [4:0]           hex_dec;
    logic                 is_digit;
    logic [ADDR_W-1:0]    head_flat;
    logic                 pinv;

    // A line end needs a free snapshot slot
    assign item_ready = !item_eol || !snap_valid_reg || snap_ready;
    assign fire       = item_valid && item_ready;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    assign hex_dec  = hex_decode(item_char);
    assign is_digit = (item_char >= CHAR_ZERO) && (item_char <= CHAR_NINE);

    // Character step, then group close
    always_comb begin
        tail_next       = tail_reg;
        count_next      = count_reg;
        gap_seen_next   = gap_seen_reg;
        prev_colon_next = prev_colon_reg;
        in_prefix_next  = in_prefix_reg;
        prefix_next     = prefix_reg;
        pdc_next        = pdc_reg;
        tab_next        = tab_reg;
        bad_next        = bad_reg;
        hex_c           = hex_reg;
        digit_c         = digit_reg;
        close_now       = 1'b0;
        for (int i = 0; i < GROUPS; i++) begin
            head_next[i] = head_reg[i];
        end

        if (item_char == CHAR_TAB) begin
            if (tab_reg != {TAB_W{1'b1}}) begin
                tab_next = tab_reg + TAB_W'(1);
            end
        end
        else if (in_prefix_reg) begin
            if (is_digit) begin
                if (pdc_reg < PFX_CNT_W'(PFX_DIGITS)) begin
                    prefix_next = (prefix_reg << 3) + (prefix_reg << 1)
                                  + {{(PFX_ACC_W-4){1'b0}}, item_char[3:0]};
                    pdc_next    = pdc_reg + PFX_CNT_W'(1);
                end
            end
            else if (pdc_reg != '0) begin
                // non-digit after digits: prefix is done
                pdc_next = PFX_CNT_W'(PFX_DIGITS);
            end
        end
        else if (item_char == CHAR_SLASH) begin
            close_now       = 1'b1;
            prev_colon_next = 1'b0;
            in_prefix_next  = 1'b1;
        end
        else if (item_char == CHAR_COLON) begin
            if (prev_colon_reg) begin
                if (gap_seen_reg) begin
                    bad_next = 1'b1;
                end
                else begin
                    gap_seen_next = 1'b1;
                end
            end
            close_now       = 1'b1;
            prev_colon_next = 1'b1;
        end
        else begin
            if (hex_dec[4]) begin
                hex_c   = {hex_reg[GROUP_W-5:0], hex_dec[3:0]};
                digit_c = 1'b1;
            end
            prev_colon_next = 1'b0;
        end

        if (item_eol) begin
            close_now = 1'b1;
        end

        // Groups before the gap land at fixed slots; after it they shift in low
        if (close_now && digit_c) begin
            if (count_reg < CNT_W'(GROUPS)) begin
                if (gap_seen_next) begin
                    tail_next = {tail_reg[ADDR_W-GROUP_W-1:0], hex_c};
                end
                else begin
                    head_next[count_reg[IDX_W-1:0]] = hex_c;
                end
                count_next = count_reg + CNT_W'(1);
            end
            else begin
                bad_next = 1'b1;
            end
        end

        if (close_now) begin
            hex_next   = '0;
            digit_next = 1'b0;
        end
        else begin
            hex_next   = hex_c;
            digit_next = digit_c;
        end
    end

    // Snapshot of the finished line
    always_comb begin
        for (int i = 0; i < GROUPS; i++) begin
            head_flat[ADDR_W-1-i*GROUP_W -: GROUP_W] = head_next[i];
        end
        pinv                    = prefix_next > PREFIX_MAX;
        snap_next.address       = head_flat | tail_next;
        snap_next.prefix_invalid = pinv;
        snap_next.prefix_length = pinv ? PREFIX_MAX[PFX_W-1:0] : prefix_next[PFX_W-1:0];
        snap_next.form_invalid  = bad_next;
        snap_next.indent_depth  = tab_next;
    end

    always_comb begin
        if (fire && item_eol) begin
            snap_valid_next = 1'b1;
        end
        else if (snap_ready) begin
            snap_valid_next = 1'b0;
        end
        else begin
            snap_valid_next = snap_valid_reg;
        end
    end

    // State registers; a line end starts the next line from zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < GROUPS; i++) begin
                head_reg[i] <= '0;
            end
            tail_reg       <= '0;
            count_reg      <= '0;
            gap_seen_reg   <= 1'b0;
            hex_reg        <= '0;
            digit_reg      <= 1'b0;
            prev_colon_reg <= 1'b0;
            in_prefix_reg  <= 1'b0;
            prefix_reg     <= '0;
            pdc_reg        <= '0;
            tab_reg        <= '0;
            bad_reg        <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else begin
            snap_valid_reg <= snap_valid_next;
            if (fire) begin
                if (item_eol) begin
                    for (int i = 0; i < GROUPS; i++) begin
                        head_reg[i] <= '0;
                    end
                    tail_reg       <= '0;
                    count_reg      <= '0;
                    gap_seen_reg   <= 1'b0;
                    hex_reg        <= '0;
                    digit_reg      <= 1'b0;
                    prev_colon_reg <= 1'b0;
                    in_prefix_reg  <= 1'b0;
                    prefix_reg     <= '0;
                    pdc_reg        <= '0;
                    tab_reg        <= '0;
                    bad_reg        <= 1'b0;
                end
                else begin
                    for (int i = 0; i < GROUPS; i++) begin
                        head_reg[i] <= head_next[i];
                    end
                    tail_reg       <= tail_next;
                    count_reg      <= count_next;
                    gap_seen_reg   <= gap_seen_next;
                    hex_reg        <= hex_next;
                    digit_reg      <= digit_next;
                    prev_colon_reg <= prev_colon_next;
                    in_prefix_reg  <= in_prefix_next;
                    prefix_reg     <= prefix_next;
                    pdc_reg        <= pdc_next;
                    tab_reg        <= tab_next;
                    bad_reg        <= bad_next;
                end
            end
        end
    end

    // Snapshot payload
    always_ff @(posedge clk)
    begin
        if (fire && item_eol) begin
            snap_reg <= snap_next;
        end
    end

endmodule

// ===== rtl/ipfx_result.sv =====
module ipfx_result
    import ipfx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    input  line_result_t       snap,
    output logic               snap_ready,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [HALF_W-1:0]  res_address_high,
    output logic [HALF_W-1:0]  res_address_low,
    output logic [HALF_W-1:0]  res_subnet_high,
    output logic [HALF_W-1:0]  res_subnet_low,
    output logic [PFX_W-1:0]   res_prefix_length,
    output logic               res_prefix_invalid,
    output logic               res_form_invalid,
    output logic [TAB_W-1:0]   res_indent_depth
);

    logic              valid_reg, valid_next;
    logic              load;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] subnet;
    logic [ADDR_W-1:0] address_reg;
    logic [ADDR_W-1:0] subnet_reg;
    logic [PFX_W-1:0]  plen_reg;
    logic              pinv_reg;
    logic              form_reg;
    logic [TAB_W-1:0]  indent_reg;

    assign snap_ready = !valid_reg || res_ready;
    assign load       = snap_valid && snap_ready;

    // Prefix mask: top prefix_length bits set
    assign mask   = ~({ADDR_W{1'b1}} >> snap.prefix_length);
    assign subnet = snap.address & mask;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end
        else if (res_ready) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            address_reg <= snap.address;
            subnet_reg  <= subnet;
            plen_reg    <= snap.prefix_length;
            pinv_reg    <= snap.prefix_invalid;
            form_reg    <= snap.form_invalid;
            indent_reg  <= snap.indent_depth;
        end
    end

    assign res_valid          = valid_reg;
    assign res_address_high   = address_reg[ADDR_W-1:HALF_W];
    assign res_address_low    = address_reg[HALF_W-1:0];
    assign res_subnet_high    = subnet_reg[ADDR_W-1:HALF_W];
    assign res_subnet_low     = subnet_reg[HALF_W-1:0];
    assign res_prefix_length  = plen_reg;
    assign res_prefix_invalid = pinv_reg;
    assign res_form_invalid   = form_reg;
    assign res_indent_depth   = indent_reg;

endmodule

// ===== rtl/ipv6_prefix_text_parser_unit.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// input    | in_valid / in_ready  | char_code, end_of_line (one character a request)
// output   | out_valid/out_ready  | address_*, subnet_*, prefix_length, flags, depth
//
// One character is accepted every cycle while in_ready is high; the parser updates its line state in
// a single step behind the input register.
// A line end lands in a snapshot register, and the mask is applied on the way
// into the result register, which drives out_valid.
// Reset clears all line state and empties every stage.
// While a result waits, one more line end fits in the snapshot register; the
// line end after that holds in the input register and in_ready drops.
module ipv6_prefix_text_parser_unit
    import ipfx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               end_of_line,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [HALF_W-1:0]  address_high,
    output logic [HALF_W-1:0]  address_low,
    output logic [HALF_W-1:0]  subnet_high,
    output logic [HALF_W-1:0]  subnet_low,
    output logic [PFX_W-1:0]   prefix_length,
    output logic               prefix_invalid,
    output logic               form_invalid,
    output logic [TAB_W-1:0]   indent_depth
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   char_reg;
    logic         eol_reg;
    logic         item_ready;
    logic         snap_valid;
    logic         snap_ready;
    line_result_t snap;
    logic         accept;

    // Input register
    assign in_ready = !in_valid_reg || item_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        if (accept) begin
            in_valid_next = 1'b1;
        end
        else if (item_ready) begin
            in_valid_next = 1'b0;
        end
        else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            char_reg <= char_code;
            eol_reg  <= end_of_line;
        end
    end

    // Line parser
    ipfx_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_char  (char_reg),
        .item_eol   (eol_reg),
        .item_ready (item_ready),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    // Mask and result register
    ipfx_result u_result (
        .clk                (clk),
        .rst_n              (rst_n),
        .snap_valid         (snap_valid),
        .snap               (snap),
        .snap_ready         (snap_ready),
        .res_valid          (out_valid),
        .res_ready          (out_ready),
        .res_address_high   (address_high),
        .res_address_low    (address_low),
        .res_subnet_high    (subnet_high),
        .res_subnet_low     (subnet_low),
        .res_prefix_length  (prefix_length),
        .res_prefix_invalid (prefix_invalid),
        .res_form_invalid   (form_invalid),
        .res_indent_depth   (indent_depth)
    );

endmodule
